// ===== src/grid_ray_clearance_unit_assert.svh =====
// Assertion macros shared by the clearance unit RTL.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef GRID_RAY_CLEARANCE_UNIT_ASSERT_SVH
`define GRID_RAY_CLEARANCE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define GRC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define GRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/grc_pkg.sv =====
// Package for the grid ray clearance unit: map geometry, field widths,
// request opcodes, controller states and the compass ray step tables.
`timescale 1ns / 1ps

package grc_pkg;

    // Map geometry
    localparam int MAP_SIDE   = 128;
    localparam int MAP_ADDR_W = $clog2(MAP_SIDE);

    // Request and result field widths
    localparam int COORD_W    = 7;
    localparam int CLR_W      = 4;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 8;

    // Walk position: one cell past either edge plus a sign bit
    localparam int POS_W = ((MAP_ADDR_W > COORD_W) ? MAP_ADDR_W : COORD_W) + 2;

    // Ray directions
    localparam int NUM_DIRS = 8;
    localparam int DIR_W    = $clog2(NUM_DIRS);

    localparam logic [CLR_W-1:0] MAX_CLR_RESET = 4'd8;

    // Request opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef logic signed [1:0] t_step;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WR_RD,
        ST_WR_WB,
        ST_Q_STEP,
        ST_Q_CHK,
        ST_Q_DONE
    } t_state;

    // Column step per direction, counterclockwise from east
    function automatic t_step ray_dx(input logic [DIR_W-1:0] dir);
        t_step s;
        case (dir)
            3'd0:    s = 2'sd1;
            3'd1:    s = 2'sd1;
            3'd2:    s = 2'sd0;
            3'd3:    s = -2'sd1;
            3'd4:    s = -2'sd1;
            3'd5:    s = -2'sd1;
            3'd6:    s = 2'sd0;
            default: s = 2'sd1;
        endcase
        return s;
    endfunction

    // Row step per direction
    function automatic t_step ray_dy(input logic [DIR_W-1:0] dir);
        t_step s;
        case (dir)
            3'd0:    s = 2'sd0;
            3'd1:    s = 2'sd1;
            3'd2:    s = 2'sd1;
            3'd3:    s = 2'sd1;
            3'd4:    s = 2'sd0;
            3'd5:    s = -2'sd1;
            3'd6:    s = -2'sd1;
            default: s = -2'sd1;
        endcase
        return s;
    endfunction

endpackage

// ===== src/grc_ram.sv =====
// Generic single-port synchronous RAM with a registered read port.
// Standalone; width and depth come from the instantiating module.
`timescale 1ns / 1ps

module grc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write when enabled with write strobe, otherwise register the read
    always_ff @(posedge i_clk) begin
        if (i_en && i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else if (i_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/grid_ray_clearance_unit.sv =====
// Grid ray clearance unit. Holds a square map of one-bit "low" flags, one
// row of the map per word of a single-port RAM. A write request is accepted,
// then its row is read and written back with the cell replaced. A query
// request walks the eight compass rays from the start cell; for each low
// cell on a ray it reads the row, then tests the cell, and a ray ends at a
// cell that is not low, off the map or when its run reaches the running
// minimum. One request is in flight at a time, and a finished result waits
// in an output register while the next request is taken. After reset a
// clearing pass writes every row to zero, during which no request is taken;
// configuration writes are taken at any time.
`timescale 1ns / 1ps

`include "grid_ray_clearance_unit_assert.svh"

module grid_ray_clearance_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Request channel
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // [6:0] cell_x, [13:7] cell_y, [14] low_flag, [15] zero
    input  logic [grc_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    // [0] opcode
    input  logic                           i_s_axis_tuser,
    // Result channel
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [3:0] clearance, [7:4] zero
    output logic [grc_pkg::M_TDATA_W-1:0]  o_m_axis_tdata,
    // Configuration write channel: max_clearance
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [grc_pkg::CLR_W-1:0]      i_cfg_data
);

    localparam int AW = grc_pkg::MAP_ADDR_W;
    localparam int CW = grc_pkg::COORD_W;
    localparam int PW = grc_pkg::POS_W;
    localparam int LW = grc_pkg::CLR_W;
    localparam int DW = grc_pkg::DIR_W;

    grc_pkg::t_state r_state, n_state;

    logic [AW-1:0]   r_clr_row;
    logic [LW-1:0]   r_max_clr;
    logic [CW-1:0]   r_x, r_y;
    logic            r_flag;
    logic [PW-1:0]   r_pos_x, r_pos_y;
    logic [LW-1:0]   r_run, r_best;
    logic [DW-1:0]   r_dir;
    logic            r_out_valid;
    logic [LW-1:0]   r_out_clr;

    // Request fields
    logic            w_in_req;
    logic            w_in_op;
    logic [CW-1:0]   w_in_x, w_in_y;
    logic            w_in_flag;
    logic            w_in_map;

    // Walk conditions
    logic            w_cap;
    logic            w_oob;
    logic            w_cell_low;
    logic            w_last_dir;
    logic            w_last_row;
    logic            w_out_load;

    // Map RAM port
    logic                    w_ram_en, w_ram_we;
    logic [AW-1:0]           w_ram_addr;
    logic [grc_pkg::MAP_SIDE-1:0] w_ram_wdata, w_ram_rdata, w_wr_row;

    grc_ram #(
        .WIDTH (grc_pkg::MAP_SIDE),
        .DEPTH (grc_pkg::MAP_SIDE)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_en    (w_ram_en),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

    // Request unpacking
    assign w_in_req  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_in_op   = i_s_axis_tuser;
    assign w_in_x    = i_s_axis_tdata[CW-1:0];
    assign w_in_y    = i_s_axis_tdata[2*CW-1:CW];
    assign w_in_flag = i_s_axis_tdata[2*CW];
    assign w_in_map  = (PW'(w_in_x) < PW'(grc_pkg::MAP_SIDE))
                    && (PW'(w_in_y) < PW'(grc_pkg::MAP_SIDE));

    // Walk status: run reached the running minimum, position off the map, cell flag
    assign w_cap      = (r_run == r_best);
    assign w_oob      = r_pos_x[PW-1] || r_pos_y[PW-1]
                     || (r_pos_x >= PW'(grc_pkg::MAP_SIDE))
                     || (r_pos_y >= PW'(grc_pkg::MAP_SIDE));
    assign w_cell_low = w_ram_rdata[r_pos_x[AW-1:0]];
    assign w_last_dir = (r_dir == DW'(grc_pkg::NUM_DIRS - 1));
    assign w_last_row = (r_clr_row == AW'(grc_pkg::MAP_SIDE - 1));
    assign w_out_load = (r_state == grc_pkg::ST_Q_DONE)
                     && (!r_out_valid || i_m_axis_tready);

    // Row with the written cell replaced
    always_comb begin
        w_wr_row = w_ram_rdata;
        w_wr_row[AW'(r_x)] = r_flag;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            grc_pkg::ST_CLEAR: begin
                if (w_last_row) begin
                    n_state = grc_pkg::ST_IDLE;
                end
            end
            grc_pkg::ST_IDLE: begin
                if (w_in_req) begin
                    if (w_in_op == grc_pkg::OP_QUERY) begin
                        n_state = grc_pkg::ST_Q_STEP;
                    end else if (w_in_map) begin
                        n_state = grc_pkg::ST_WR_RD;
                    end
                end
            end
            grc_pkg::ST_WR_RD: n_state = grc_pkg::ST_WR_WB;
            grc_pkg::ST_WR_WB: n_state = grc_pkg::ST_IDLE;
            grc_pkg::ST_Q_STEP: begin
                if (w_cap || w_oob) begin
                    if (w_last_dir) begin
                        n_state = grc_pkg::ST_Q_DONE;
                    end
                end else begin
                    n_state = grc_pkg::ST_Q_CHK;
                end
            end
            grc_pkg::ST_Q_CHK: begin
                if (w_cell_low || !w_last_dir) begin
                    n_state = grc_pkg::ST_Q_STEP;
                end else begin
                    n_state = grc_pkg::ST_Q_DONE;
                end
            end
            grc_pkg::ST_Q_DONE: begin
                if (w_out_load) begin
                    n_state = grc_pkg::ST_IDLE;
                end
            end
            default: n_state = grc_pkg::ST_IDLE;
        endcase
    end

    // Outputs: request ready and map RAM port
    always_comb begin
        o_s_axis_tready = 1'b0;
        w_ram_en        = 1'b0;
        w_ram_we        = 1'b0;
        w_ram_addr      = r_pos_y[AW-1:0];
        w_ram_wdata     = w_wr_row;
        case (r_state)
            grc_pkg::ST_CLEAR: begin
                w_ram_en    = 1'b1;
                w_ram_we    = 1'b1;
                w_ram_addr  = r_clr_row;
                w_ram_wdata = '0;
            end
            grc_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
            end
            grc_pkg::ST_WR_RD: begin
                w_ram_en   = 1'b1;
                w_ram_addr = AW'(r_y);
            end
            grc_pkg::ST_WR_WB: begin
                w_ram_en   = 1'b1;
                w_ram_we   = 1'b1;
                w_ram_addr = AW'(r_y);
            end
            grc_pkg::ST_Q_STEP: begin
                w_ram_en = !(w_cap || w_oob);
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= grc_pkg::ST_CLEAR;
            r_clr_row   <= '0;
            r_max_clr   <= grc_pkg::MAX_CLR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == grc_pkg::ST_CLEAR) begin
                r_clr_row <= r_clr_row + AW'(1);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_clr <= i_cfg_data;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request and walk datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            grc_pkg::ST_IDLE: begin
                if (w_in_req) begin
                    r_x     <= w_in_x;
                    r_y     <= w_in_y;
                    r_flag  <= w_in_flag;
                    r_pos_x <= PW'(w_in_x);
                    r_pos_y <= PW'(w_in_y);
                    r_run   <= '0;
                    r_best  <= r_max_clr;
                    r_dir   <= '0;
                end
            end
            grc_pkg::ST_Q_STEP: begin
                if (w_cap || w_oob) begin
                    // ray ends; a short run lowers the running minimum
                    if (!w_cap) begin
                        r_best <= r_run;
                    end
                    r_dir   <= r_dir + DW'(1);
                    r_pos_x <= PW'(r_x);
                    r_pos_y <= PW'(r_y);
                    r_run   <= '0;
                end
            end
            grc_pkg::ST_Q_CHK: begin
                if (w_cell_low) begin
                    r_run   <= r_run + LW'(1);
                    r_pos_x <= r_pos_x + PW'(grc_pkg::ray_dx(r_dir));
                    r_pos_y <= r_pos_y + PW'(grc_pkg::ray_dy(r_dir));
                end else begin
                    r_best  <= r_run;
                    r_dir   <= r_dir + DW'(1);
                    r_pos_x <= PW'(r_x);
                    r_pos_y <= PW'(r_y);
                    r_run   <= '0;
                end
            end
            grc_pkg::ST_Q_DONE: begin
                if (w_out_load) begin
                    r_out_clr <= r_best;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = grc_pkg::M_TDATA_W'(r_out_clr);
    assign o_cfg_ready     = 1'b1;

    // Checks
    `GRC_ASSERT_NOW(a_run_within_best,
        (r_state == grc_pkg::ST_Q_STEP) || (r_state == grc_pkg::ST_Q_CHK),
        r_run <= r_best, "ray run exceeds running minimum")
    `GRC_ASSERT_NOW(a_best_within_cap,
        (r_state == grc_pkg::ST_Q_STEP) || (r_state == grc_pkg::ST_Q_DONE),
        r_best <= r_max_clr, "running minimum exceeds the configured cap")
    `GRC_ASSERT_NOW(a_no_write_in_query,
        (r_state == grc_pkg::ST_Q_STEP) || (r_state == grc_pkg::ST_Q_CHK),
        !w_ram_we, "map written during a query walk")
    `GRC_ASSERT_NEXT(a_chk_after_read,
        (r_state == grc_pkg::ST_Q_STEP) && w_ram_en,
        r_state == grc_pkg::ST_Q_CHK, "map read not followed by a cell test")
    `GRC_ASSERT_NOW(a_result_from_done,
        $rose(r_out_valid),
        $past(r_state) == grc_pkg::ST_Q_DONE, "result raised outside query end")

endmodule
